/* rtl/sfb_pkg.sv */
// shared constants, command types and helpers for the rectangle-fill frame store
// no dependencies
package sfb_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;

    // coordinate and address widths
    localparam int XW = $clog2(SCREEN_WIDTH + 1);
    localparam int YW = $clog2(SCREEN_HEIGHT + 1);
    localparam int AW = $clog2(STORE_SIZE);

    // command queue depth
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // reciprocal of 3 in 16 fractional bits, exact for dividends below 32768
    localparam int Y_RECIP = 21846;

    // function codes on the input channel
    localparam logic [1:0] FUNC_SIZE    = 2'd0;
    localparam logic [1:0] FUNC_CORNERS = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    // classified command kinds
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_FILL = 2'd1,
        K_READ = 2'd2
    } t_kind;

    // one classified command, clipped to the screen
    typedef struct packed {
        t_kind           kind;
        logic [XW-1:0]   x0;
        logic [XW-1:0]   x1;
        logic [YW-1:0]   y0;
        logic [YW-1:0]   y1;
        logic [7:0]      index;
        logic [AW-1:0]   addr;
    } t_cmd;

    // rgb to 2-3-3 palette index
    function automatic logic [7:0] rgb_to_index(input logic [7:0] red,
                                                input logic [7:0] green,
                                                input logic [7:0] blue);
        rgb_to_index = {red[7:6], green[7:5], blue[7:5]};
    endfunction

endpackage

/* rtl/sfb_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module sfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/sfb_front.sv */
// front end: accepts commands, scales and clips the box, classifies the command
// depends on sfb_pkg
module sfb_front
    import sfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic signed [11:0]   i_x_start,
    input  logic signed [11:0]   i_y_start,
    input  logic signed [11:0]   i_x_extent,
    input  logic signed [11:0]   i_y_extent,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  logic [15:0]          i_pixel_address,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    input  logic                 i_full
);

    // stage one registers
    logic          r_s1_valid, n_s1_valid;
    logic [1:0]    r_func;
    logic [9:0]    r_x0h;
    logic [10:0]   r_x1h;
    logic [12:0]   r_w0;
    logic [12:0]   r_w1;
    logic [7:0]    r_index;
    logic          r_rd_ok;
    logic [AW-1:0] r_addr;

    logic          accept, take;
    logic signed [12:0] x1_sum, y1_sum;
    logic [10:0]   x0_pos;
    logic [11:0]   x1_pos;
    logic [10:0]   y0_pos;
    logic [11:0]   y1_pos;
    logic [13:0]   y0_x5;
    logic [14:0]   y1_x5;

    logic [28:0]   p0, p1;
    logic [11:0]   x0_c, x1_c, y0_c, y1_c, x1_m, y1_m;
    logic [11:0]   lim_x, lim_y;
    logic          box_empty;
    t_kind         kind;

    assign take       = r_s1_valid && !i_full;
    assign o_in_stall = r_s1_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;

    // end corners, as width/height or as a corner
    always_comb begin
        if (i_func == FUNC_SIZE) begin
            x1_sum = 13'(i_x_start) + 13'(i_x_extent);
            y1_sum = 13'(i_y_start) + 13'(i_y_extent);
        end else begin
            x1_sum = 13'(i_x_extent);
            y1_sum = 13'(i_y_extent);
        end
    end

    // negative bounds clip to zero either way, so clamp before scaling
    assign x0_pos = i_x_start[11] ? 11'd0 : i_x_start[10:0];
    assign x1_pos = x1_sum[12]    ? 12'd0 : x1_sum[11:0];
    assign y0_pos = i_y_start[11] ? 11'd0 : i_y_start[10:0];
    assign y1_pos = y1_sum[12]    ? 12'd0 : y1_sum[11:0];

    // y times 5, divided by 4 here and by 3 after the stage one registers
    assign y0_x5 = {1'b0, y0_pos, 2'b00} + 14'(y0_pos);
    assign y1_x5 = {1'b0, y1_pos, 2'b00} + 15'(y1_pos);

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (take) begin
            n_s1_valid = 1'b0;
        end
    end

    // stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_x0h   <= x0_pos[10:1];
            r_x1h   <= x1_pos[11:1];
            r_w0    <= 13'(y0_x5[13:2]);
            r_w1    <= y1_x5[14:2];
            r_index <= rgb_to_index(i_red, i_green, i_blue);
            r_rd_ok <= (32'(i_pixel_address) < 32'(STORE_SIZE));
            r_addr  <= AW'(i_pixel_address);
        end
    end

    // divide by 3 through the reciprocal
    assign p0 = 29'(r_w0) * 29'(Y_RECIP);
    assign p1 = 29'(r_w1) * 29'(Y_RECIP);

    // clip to the screen
    assign lim_x = 12'(SCREEN_WIDTH);
    assign lim_y = 12'(SCREEN_HEIGHT);
    assign x0_c  = 12'(r_x0h);
    assign x1_c  = 12'(r_x1h);
    assign y0_c  = 12'(p0[26:16]);
    assign y1_c  = 12'(p1[26:16]);
    assign x1_m  = (x1_c > lim_x) ? lim_x : x1_c;
    assign y1_m  = (y1_c > lim_y) ? lim_y : y1_c;
    assign box_empty = (x1_m <= x0_c) || (y1_m <= y0_c);

    // classify
    always_comb begin
        case (r_func)
            FUNC_SIZE, FUNC_CORNERS: kind = box_empty ? K_NONE : K_FILL;
            FUNC_READ:               kind = r_rd_ok ? K_READ : K_NONE;
            default:                 kind = K_NONE;
        endcase
    end

    assign o_push       = take;
    assign o_cmd.kind   = kind;
    assign o_cmd.x0     = XW'(x0_c);
    assign o_cmd.x1     = XW'(x1_m);
    assign o_cmd.y0     = YW'(y0_c);
    assign o_cmd.y1     = YW'(y1_m);
    assign o_cmd.index  = r_index;
    assign o_cmd.addr   = r_addr;

endmodule

/* rtl/sfb_queue.sv */
// short command queue between front and back ends
// depends on sfb_pkg
module sfb_queue
    import sfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd           r_slot [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_count,  n_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty command queue");

endmodule

/* rtl/sfb_back.sv */
// back end: walks the clipped box into the frame store, serves reads, holds the result
// depends on sfb_pkg and sfb_ram
module sfb_back
    import sfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_pixel_index,
    output logic [15:0] o_pixels_written
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RADDR = 5'b00010,
        S_RDATA = 5'b00100,
        S_FILL  = 5'b01000,
        S_POST  = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    logic [XW-1:0]  r_x, r_x0, r_x1;
    logic [YW-1:0]  r_y, r_y1;
    logic [AW-1:0]  r_row_base;
    logic [AW-1:0]  r_rd_addr;
    logic [7:0]     r_index;
    logic [7:0]     r_res_pix;
    logic [15:0]    r_res_cnt;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_pixel_index;
    logic [15:0]    r_pixels_written;

    logic           x_last, y_last, ram_we, slot_free;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     rd_data;

    assign x_last    = (r_x == r_x1 - XW'(1));
    assign y_last    = (r_y == r_y1 - YW'(1));
    assign ram_we    = (r_state == S_FILL);
    assign wr_addr   = r_row_base + AW'(r_x);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE) && i_valid;

    sfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_index),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.kind)
                        K_FILL:  n_state = S_FILL;
                        K_READ:  n_state = S_RADDR;
                        default: n_state = S_POST;
                    endcase
                end
            end
            S_RADDR: n_state = S_RDATA;
            S_RDATA: n_state = S_POST;
            S_FILL: begin
                if (x_last && y_last) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_POST && slot_free) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // box walk and result datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x        <= i_cmd.x0;
                r_x0       <= i_cmd.x0;
                r_x1       <= i_cmd.x1;
                r_y        <= i_cmd.y0;
                r_y1       <= i_cmd.y1;
                r_index    <= i_cmd.index;
                r_row_base <= AW'(i_cmd.y0) * AW'(SCREEN_WIDTH);
                r_rd_addr  <= i_cmd.addr;
                r_res_pix  <= 8'd0;
                r_res_cnt  <= 16'd0;
            end
            S_RDATA: begin
                r_res_pix <= rd_data;
            end
            S_FILL: begin
                r_res_cnt <= r_res_cnt + 16'd1;
                if (x_last) begin
                    r_x        <= r_x0;
                    r_y        <= r_y + YW'(1);
                    r_row_base <= r_row_base + AW'(SCREEN_WIDTH);
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
            default: begin
                r_res_pix <= r_res_pix;
            end
        endcase
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_POST && slot_free) begin
            r_pixel_index    <= r_res_pix;
            r_pixels_written <= r_res_cnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_index    = r_pixel_index;
    assign o_pixels_written = r_pixels_written;

    a_write_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_x < r_x1) && (r_y < r_y1))
        else $error("fill write outside the clipped box");

    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(wr_addr) < 32'(STORE_SIZE)))
        else $error("fill write beyond the frame store");

    a_read_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RADDR) |=> (r_state == S_RDATA))
        else $error("read data phase skipped");

    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && x_last && y_last) |=> (r_state == S_POST))
        else $error("fill did not finish at the last pixel");

endmodule

/* rtl/scaled_rect_fill_framebuffer.sv */
// top level of the rectangle-fill engine over a 320x200 palette-index frame store
// depends on sfb_pkg, sfb_front, sfb_queue, sfb_back
// path: a command passes the front end stage one register, the command queue and the back
// end sequencer; its result is then held in the back end output register
// throughput: the back end handles one command at a time, one pixel
// written per cycle through the single frame store write port
// reset: synchronous active-low clears control state; the frame store is not cleared and
// holds undefined data until a fill writes it
module scaled_rect_fill_framebuffer
    import sfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [11:0] i_x_start,
    input  logic signed [11:0] i_y_start,
    input  logic signed [11:0] i_x_extent,
    input  logic signed [11:0] i_y_extent,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [15:0]        i_pixel_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_pixel_index,
    output logic [15:0]        o_pixels_written
);

    logic push, full, pop, q_valid;
    t_cmd push_cmd, head_cmd;

    // classify and clip
    sfb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_extent      (i_x_extent),
        .i_y_extent      (i_y_extent),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_pixel_address (i_pixel_address),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_full          (full)
    );

    // decoupling queue
    sfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // execute against the frame store
    sfb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pixel_index    (o_pixel_index),
        .o_pixels_written (o_pixels_written)
    );

endmodule

/* test/sfb_checker.sv */
`timescale 1ns / 100ps
// result checker for the rectangle-fill frame store: predicts every input transfer
// and compares each output transfer with the oldest prediction; depends on sfb_pkg
module sfb_checker
    import sfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [11:0] i_x_start,
    input  logic signed [11:0] i_y_start,
    input  logic signed [11:0] i_x_extent,
    input  logic signed [11:0] i_y_extent,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [15:0]        i_pixel_address,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [7:0]         i_pixel_index,
    input  logic [15:0]        i_pixels_written,
    output int                 o_fail_count,
    output int                 o_pending
);

    // rows map from 480-high space onto the screen by 200/480
    localparam int ROW_SCALE_MUL = 200;
    localparam int ROW_SCALE_DIV = 480;

    typedef struct {
        logic [7:0]  pixel_index;
        logic [15:0] pixels_written;
    } t_answer;

    logic [7:0] frame_model [STORE_SIZE];
    t_answer    answer_fifo [$];
    int         mismatch_count = 0;

    // signed division truncates toward zero, as the block does
    function automatic int scale_row(input int y);
        return (y * ROW_SCALE_MUL) / ROW_SCALE_DIV;
    endfunction

    // paint the clipped half-open box into the model store and count the cells
    function automatic logic [15:0] paint_box(input int x0, input int y0, input int x1,
                                              input int y1, input logic [7:0] index);
        int count;
        count = 0;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > SCREEN_WIDTH) x1 = SCREEN_WIDTH;
        if (y1 > SCREEN_HEIGHT) y1 = SCREEN_HEIGHT;
        for (int y = y0; y < y1; y++) begin
            for (int x = x0; x < x1; x++) begin
                frame_model[16'(y * SCREEN_WIDTH + x)] = index;
                count++;
            end
        end
        return count[15:0];
    endfunction

    // expected answer of one command, updating the model store for fills
    function automatic t_answer predict_answer(input logic [1:0] func, input int xs,
                                               input int ys, input int xe, input int ye,
                                               input logic [7:0] red,
                                               input logic [7:0] green,
                                               input logic [7:0] blue,
                                               input logic [15:0] addr);
        t_answer    ans;
        logic [7:0] index;
        ans.pixel_index    = '0;
        ans.pixels_written = '0;
        index = {red[7:6], 6'b0} | {2'b0, green[7:5], 3'b0} | {5'b0, blue[7:5]};
        case (func)
            FUNC_SIZE: begin
                ans.pixels_written = paint_box(xs / 2, scale_row(ys), (xs + xe) / 2,
                                               scale_row(ys + ye), index);
            end
            FUNC_CORNERS: begin
                ans.pixels_written = paint_box(xs / 2, scale_row(ys), xe / 2,
                                               scale_row(ye), index);
            end
            FUNC_READ: begin
                if (int'(addr) < STORE_SIZE) ans.pixel_index = frame_model[addr];
            end
            default: begin
                // unused code: no effect, zero answer
            end
        endcase
        return ans;
    endfunction

    // compare output transfers first, then queue the prediction for an input transfer
    always @(posedge i_clk) begin : monitor
        t_answer seen;
        t_answer want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_pixel_index, i_pixels_written};
                if (answer_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual index %0d count %0d",
                             $time, seen.pixel_index, seen.pixels_written);
                    mismatch_count++;
                end else begin
                    want = answer_fifo.pop_front();
                    if (seen.pixel_index !== want.pixel_index) begin
                        $display("%0t: pixel_index expected %0d actual %0d",
                                 $time, want.pixel_index, seen.pixel_index);
                        mismatch_count++;
                    end
                    if (seen.pixels_written !== want.pixels_written) begin
                        $display("%0t: pixels_written expected %0d actual %0d",
                                 $time, want.pixels_written, seen.pixels_written);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                answer_fifo.push_back(predict_answer(i_func, int'(i_x_start),
                                                     int'(i_y_start), int'(i_x_extent),
                                                     int'(i_y_extent), i_red, i_green,
                                                     i_blue, i_pixel_address));
            end
        end
        o_pending    <= answer_fifo.size();
        o_fail_count <= mismatch_count;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// top of the rectangle-fill frame store testbench: clock, reset, commands and verdict
// depends on sfb_pkg, scaled_rect_fill_framebuffer and sfb_checker
module tb;
    import sfb_pkg::*;

    localparam logic [1:0] FUNC_NOP       = 2'd3;
    localparam int         WATCHDOG_LIMIT = 300000;
    localparam int         RANDOM_COUNT   = 100;
    localparam int         QUIET_FROM     = 80;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd_func;
    logic signed [11:0] x_start;
    logic signed [11:0] y_start;
    logic signed [11:0] x_extent;
    logic signed [11:0] y_extent;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [15:0]        pixel_address;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         pixel_index;
    logic [15:0]        pixels_written;
    int                 fail_count;
    int                 pending;
    logic               quiet;
    int                 idle_cycles;

    scaled_rect_fill_framebuffer i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_func           (cmd_func),
        .i_x_start        (x_start),
        .i_y_start        (y_start),
        .i_x_extent       (x_extent),
        .i_y_extent       (y_extent),
        .i_red            (red),
        .i_green          (green),
        .i_blue           (blue),
        .i_pixel_address  (pixel_address),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_pixel_index    (pixel_index),
        .o_pixels_written (pixels_written)
    );

    sfb_checker result_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_func           (cmd_func),
        .i_x_start        (x_start),
        .i_y_start        (y_start),
        .i_x_extent       (x_extent),
        .i_y_extent       (y_extent),
        .i_red            (red),
        .i_green          (green),
        .i_blue           (blue),
        .i_pixel_address  (pixel_address),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_pixel_index    (pixel_index),
        .i_pixels_written (pixels_written),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // random stall bursts on the result side, none in the quiet tail
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one command, with an optional idle burst first, and hold it until transfer
    task automatic issue_command(input logic [1:0] func, input int xs, input int ys,
                                 input int xe, input int ye, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b,
                                 input logic [15:0] addr);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd_func      <= func;
        x_start       <= xs[11:0];
        y_start       <= ys[11:0];
        x_extent      <= xe[11:0];
        y_extent      <= ye[11:0];
        red           <= r;
        green         <= g;
        blue          <= b;
        pixel_address <= addr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int         sel;
        int         xs;
        int         ys;
        logic [1:0] func;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd_func      <= FUNC_SIZE;
        x_start       <= '0;
        y_start       <= '0;
        x_extent      <= '0;
        y_extent      <= '0;
        red           <= '0;
        green         <= '0;
        blue          <= '0;
        pixel_address <= '0;
        quiet         <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // whole screen by extreme corners, so every later read hits written cells
        issue_command(FUNC_CORNERS, -2048, -2048, 2047, 2047, 8'h00, 8'h00, 8'h00, 16'h0000);
        issue_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 16'd0);
        // whole screen by exact size, white
        issue_command(FUNC_SIZE, 0, 0, 640, 480, 8'hff, 8'hff, 8'hff, 16'h0000);
        issue_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 16'(STORE_SIZE - 1));
        // reads beyond the store
        issue_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 16'(STORE_SIZE));
        issue_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 16'hffff);
        // box hanging off the top left corner
        issue_command(FUNC_SIZE, -10, -10, 30, 30, 8'hc0, 8'h20, 8'he0, 16'h0000);
        issue_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 16'd0);
        // inverted boxes write nothing
        issue_command(FUNC_SIZE, 100, 100, -50, 40, 8'h40, 8'h40, 8'h40, 16'h0000);
        issue_command(FUNC_CORNERS, 300, 300, 100, 100, 8'h40, 8'h40, 8'h40, 16'h0000);
        // box clipped at the bottom right corner
        issue_command(FUNC_CORNERS, 600, 400, 2047, 2047, 8'h40, 8'h80, 8'h20, 16'h0000);
        issue_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 16'(STORE_SIZE - 1));
        // box entirely off screen
        issue_command(FUNC_CORNERS, 700, 500, 900, 600, 8'h80, 8'h80, 8'h80, 16'h0000);
        // truncation toward zero on small negative origins gives a single cell
        issue_command(FUNC_SIZE, -1, -1, 4, 5, 8'h3f, 8'h1f, 8'h1f, 16'h0000);
        issue_command(FUNC_READ, 0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 16'd0);
        // largest origin with most negative size
        issue_command(FUNC_SIZE, 2047, 2047, -2048, -2048, 8'hff, 8'h00, 8'hff, 16'h0000);
        // zero width
        issue_command(FUNC_SIZE, 10, 10, 0, 50, 8'hff, 8'hff, 8'h00, 16'h0000);
        // unused function code
        issue_command(FUNC_NOP, -2048, 2047, -2048, 2047, 8'hff, 8'hff, 8'hff, 16'hffff);

        // random commands: mostly small fills and reads, a few large or junk ones
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            quiet <= (n >= QUIET_FROM);
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                func = $urandom_range(0, 1) ? FUNC_CORNERS : FUNC_SIZE;
                xs   = int'($urandom_range(0, 720)) - 40;
                ys   = int'($urandom_range(0, 560)) - 40;
                if (func == FUNC_SIZE) begin
                    issue_command(func, xs, ys, int'($urandom_range(0, 80)) - 10,
                                  int'($urandom_range(0, 80)) - 10,
                                  8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
                end else begin
                    issue_command(func, xs, ys, xs + int'($urandom_range(0, 80)) - 10,
                                  ys + int'($urandom_range(0, 80)) - 10,
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
                end
            end else if (sel < 45) begin
                issue_command($urandom_range(0, 1) ? FUNC_CORNERS : FUNC_SIZE,
                              int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end else if (sel < 48) begin
                issue_command(FUNC_SIZE, 0, 0, 640, 480, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
            end else if (sel < 94) begin
                // reads carry junk coordinates and colour; a few go past the store
                issue_command(FUNC_READ, int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)),
                              16'((sel < 88) ? $urandom_range(0, STORE_SIZE - 1)
                                             : $urandom_range(0, 65535)));
            end else begin
                issue_command(FUNC_NOP, int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              int'($urandom_range(0, 4095)) - 2048,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end
        end
        in_valid <= 1'b0;

        // drain, then watch a little longer for stray results
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
